@@ hdl/ptik_pkg.sv @@
// Shared types, sizes and request/status codes for the priority table.
package ptik_pkg;

    localparam int SLOTS      = 16;
    localparam int RANK_MAX   = 255;
    localparam int DATA_WIDTH = 32;
    localparam int SEQ_W      = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int RANK_W     = $clog2(RANK_MAX + 1);

    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_PROMOTE = 3'd1;
    localparam logic [2:0] REQ_PEEK    = 3'd2;
    localparam logic [2:0] REQ_POP     = 3'd3;
    localparam logic [2:0] REQ_ISVALID = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_VALID = 3'd3;
    localparam logic [2:0] ST_SATURATED = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  slot_id;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  out_slot;
        logic [31:0] out_value;
        logic [7:0]  out_rank;
        logic        slot_valid;
    } rsp_t;

    // Word that walks down the cell chain, one cell per cycle.
    typedef struct packed {
        logic [2:0]            op;
        logic [3:0]            sid;
        logic [DATA_WIDTH-1:0] item;
        logic [SEQ_W-1:0]      seq;
        logic                  hit;
        logic                  sat;
        logic [SLOT_W-1:0]     slot;
        logic [RANK_W-1:0]     rank;
        logic [SEQ_W-1:0]      bseq;
        logic [DATA_WIDTH-1:0] value;
    } probe_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
    } clr_t;

endpackage

@@ hdl/ptik_cell.sv @@
// One table slot: holds its entry and updates the probe word passing through.
module ptik_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ptik_pkg::SLOT_W-1:0] idx,
    input  logic                     probe_vld_in,
    input  ptik_pkg::probe_t         probe_in,
    input  ptik_pkg::clr_t           clr,
    output logic                     probe_vld_out,
    output ptik_pkg::probe_t         probe_out
);
    import ptik_pkg::*;

    logic                  valid_reg, valid_next;
    logic [DATA_WIDTH-1:0] payload_reg, payload_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic                  probe_vld_reg;
    probe_t                probe_reg, probe_next;
    logic                  addressed;
    logic                  better;

    assign addressed = (32'(probe_in.sid) == 32'(idx)) && valid_reg;
    assign better    = !probe_in.hit || (rank_reg > probe_in.rank) ||
                       ((rank_reg == probe_in.rank) && (seq_reg > probe_in.bseq));

    always_comb
    begin
        valid_next   = valid_reg;
        payload_next = payload_reg;
        rank_next    = rank_reg;
        seq_next     = seq_reg;
        probe_next   = probe_in;
        if (probe_vld_in)
        begin
            case (probe_in.op)
                REQ_ADD:
                begin
                    // lowest free slot takes the item
                    if (!probe_in.hit && !valid_reg)
                    begin
                        valid_next      = 1'b1;
                        payload_next    = probe_in.item;
                        rank_next       = '0;
                        seq_next        = probe_in.seq;
                        probe_next.hit  = 1'b1;
                        probe_next.slot = idx;
                    end
                end
                REQ_PROMOTE:
                begin
                    if (addressed)
                    begin
                        probe_next.hit = 1'b1;
                        if (rank_reg >= RANK_W'(RANK_MAX))
                        begin
                            probe_next.sat = 1'b1;
                        end
                        else
                        begin
                            rank_next = rank_reg + 1'b1;
                        end
                        probe_next.rank = rank_next;
                    end
                end
                REQ_PEEK, REQ_POP:
                begin
                    if (valid_reg && better)
                    begin
                        probe_next.hit   = 1'b1;
                        probe_next.slot  = idx;
                        probe_next.rank  = rank_reg;
                        probe_next.bseq  = seq_reg;
                        probe_next.value = payload_reg;
                    end
                end
                REQ_ISVALID, REQ_READ:
                begin
                    if (addressed)
                    begin
                        probe_next.hit   = 1'b1;
                        probe_next.rank  = rank_reg;
                        probe_next.value = payload_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // pop removal arrives after the scan, never alongside a probe here
        if (clr.en && (clr.slot == idx))
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            probe_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            probe_vld_reg <= probe_vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        rank_reg    <= rank_next;
        seq_reg     <= seq_next;
        probe_reg   <= probe_next;
    end

    assign probe_vld_out = probe_vld_reg;
    assign probe_out     = probe_reg;

endmodule

@@ hdl/priority_table_increase_key.sv @@
// Priority table with increase-key: chain of slot cells plus request control.
//
// Request word (req) enters on req_valid with req_stall low; one response
// word (rsp) leaves on rsp_valid with rsp_stall low, exactly one per request.
// Every request launches a probe word into a chain of SLOTS cells; the probe
// moves one cell per clock and the response register loads as the probe
// leaves the last cell. One request is in flight at a time; req_stall is
// high from accept until the response is loaded, so a new request is not
// taken before the response to the last one has been loaded.
// A pop frees the winning slot in the cycle the probe leaves the chain.
// If the receiver stalls, the response holds steady in the output register;
// a finished result behind it waits in a holding register and new requests
// stay stalled until it moves out.
// Reset (rst_n low, asynchronous) empties the table, clears the sequence
// counter and drops rsp_valid; no clearing pass is needed.
module priority_table_increase_key (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ptik_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ptik_pkg::rsp_t   rsp
);
    import ptik_pkg::*;

    typedef enum logic [1:0] {IDLE, BUSY, HOLD} state_t;

    state_t           state_reg, state_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;
    rsp_t             hold_reg, hold_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;

    logic             chain_vld [0:SLOTS];
    probe_t           chain     [0:SLOTS];
    clr_t             clr;
    probe_t           tail;
    rsp_t             result;
    logic             accept;
    logic             out_free;

    assign accept   = req_valid && (state_reg == IDLE);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        chain_vld[0]   = accept;
        chain[0]       = '0;
        chain[0].op    = req.req_type;
        chain[0].sid   = req.slot_id;
        chain[0].item  = DATA_WIDTH'(req.item_value);
        chain[0].seq   = next_seq_reg;
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            ptik_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .idx           (SLOT_W'(g)),
                .probe_vld_in  (chain_vld[g]),
                .probe_in      (chain[g]),
                .clr           (clr),
                .probe_vld_out (chain_vld[g+1]),
                .probe_out     (chain[g+1])
            );
        end
    endgenerate

    assign tail     = chain[SLOTS];
    assign clr.en   = chain_vld[SLOTS] && (tail.op == REQ_POP) && tail.hit;
    assign clr.slot = tail.slot;

    // Response word from the probe leaving the chain.
    always_comb
    begin
        result = '0;
        case (tail.op)
            REQ_ADD:
            begin
                if (tail.hit)
                begin
                    result.status     = ST_OK;
                    result.out_slot   = 4'(tail.slot);
                    result.slot_valid = 1'b1;
                end
                else
                begin
                    result.status = ST_FULL;
                end
            end
            REQ_PROMOTE:
            begin
                result.out_slot = tail.sid;
                if (!tail.hit)
                begin
                    result.status = ST_NOT_VALID;
                end
                else
                begin
                    result.status     = tail.sat ? ST_SATURATED : ST_OK;
                    result.out_rank   = 8'(tail.rank);
                    result.slot_valid = 1'b1;
                end
            end
            REQ_PEEK, REQ_POP:
            begin
                if (!tail.hit)
                begin
                    result.status = ST_EMPTY;
                end
                else
                begin
                    result.status     = ST_OK;
                    result.out_slot   = 4'(tail.slot);
                    result.out_value  = 32'(tail.value);
                    result.out_rank   = 8'(tail.rank);
                    result.slot_valid = (tail.op == REQ_PEEK);
                end
            end
            REQ_ISVALID:
            begin
                result.status   = ST_OK;
                result.out_slot = tail.sid;
                if (tail.hit)
                begin
                    result.out_rank   = 8'(tail.rank);
                    result.slot_valid = 1'b1;
                end
            end
            REQ_READ:
            begin
                result.out_slot = tail.sid;
                if (!tail.hit)
                begin
                    result.status = ST_NOT_VALID;
                end
                else
                begin
                    result.status     = ST_OK;
                    result.out_value  = 32'(tail.value);
                    result.out_rank   = 8'(tail.rank);
                    result.slot_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        hold_next      = hold_reg;
        next_seq_next  = next_seq_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    state_next = BUSY;
                end
            end
            BUSY:
            begin
                if (chain_vld[SLOTS])
                begin
                    if ((tail.op == REQ_ADD) && tail.hit)
                    begin
                        next_seq_next = next_seq_reg + 1'b1;
                    end
                    if (out_free)
                    begin
                        rsp_next       = result;
                        rsp_valid_next = 1'b1;
                        state_next     = IDLE;
                    end
                    else
                    begin
                        hold_next  = result;
                        state_next = HOLD;
                    end
                end
            end
            HOLD:
            begin
                if (out_free)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            hold_reg      <= '0;
            next_seq_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            hold_reg      <= hold_next;
            next_seq_reg  <= next_seq_next;
        end
    end

    assign req_stall = (state_reg != IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the priority table with increase-key.
module tb;
    import ptik_pkg::*;

    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int GEN_VIEW = 0;
    localparam int CHK_VIEW = 1;
    localparam int N_ITEMS  = 1050;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Two copies of the table: one steers the generator, one checks the DUT.
    logic                  tab_valid    [2][SLOTS];
    logic [DATA_WIDTH-1:0] tab_payload  [2][SLOTS];
    logic [RANK_W-1:0]     tab_rank     [2][SLOTS];
    logic [SEQ_W-1:0]      tab_seq      [2][SLOTS];
    logic [SEQ_W-1:0]      tab_next_seq [2];

    req_t pending_reqs [$];
    rsp_t rsp_expected [$];

    int          n_gen = 0;
    int          n_acc = 0;
    int          n_rsp = 0;
    int          fail_cnt = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned cyc_cnt = 0;
    int unsigned hold_left = 0;

    priority_table_increase_key dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to a view of the table and return its response.
    function automatic rsp_t table_step(input int v, input req_t r);
        rsp_t o;
        int   i;
        int   best;
        logic hit;
        o = '0;
        best = -1;
        hit = tab_valid[v][r.slot_id];
        case (r.req_type)
            REQ_ADD:
            begin
                o.status = ST_FULL;
                for (i = 0; i < SLOTS; i++)
                begin
                    if (best < 0 && !tab_valid[v][i])
                        best = i;
                end
                if (best >= 0)
                begin
                    tab_valid[v][best]   = 1'b1;
                    tab_payload[v][best] = r.item_value;
                    tab_rank[v][best]    = '0;
                    tab_seq[v][best]     = tab_next_seq[v];
                    tab_next_seq[v]      = tab_next_seq[v] + 1'b1;
                    o.status     = ST_OK;
                    o.out_slot   = 4'(best);
                    o.slot_valid = 1'b1;
                end
            end
            REQ_PROMOTE:
            begin
                o.out_slot = r.slot_id;
                if (!hit)
                    o.status = ST_NOT_VALID;
                else
                begin
                    if (tab_rank[v][r.slot_id] >= RANK_W'(RANK_MAX))
                        o.status = ST_SATURATED;
                    else
                    begin
                        tab_rank[v][r.slot_id] = tab_rank[v][r.slot_id] + 1'b1;
                        o.status = ST_OK;
                    end
                    o.out_rank   = tab_rank[v][r.slot_id];
                    o.slot_valid = 1'b1;
                end
            end
            REQ_PEEK, REQ_POP:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (tab_valid[v][i] &&
                        (best < 0 || tab_rank[v][i] > tab_rank[v][best] ||
                         (tab_rank[v][i] == tab_rank[v][best] &&
                          tab_seq[v][i] > tab_seq[v][best])))
                        best = i;
                end
                if (best < 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.status     = ST_OK;
                    o.out_slot   = 4'(best);
                    o.out_value  = tab_payload[v][best];
                    o.out_rank   = tab_rank[v][best];
                    o.slot_valid = (r.req_type == REQ_PEEK);
                    if (r.req_type == REQ_POP)
                        tab_valid[v][best] = 1'b0;
                end
            end
            REQ_ISVALID:
            begin
                o.status   = ST_OK;
                o.out_slot = r.slot_id;
                if (hit)
                begin
                    o.out_rank   = tab_rank[v][r.slot_id];
                    o.slot_valid = 1'b1;
                end
            end
            REQ_READ:
            begin
                o.out_slot = r.slot_id;
                if (!hit)
                    o.status = ST_NOT_VALID;
                else
                begin
                    o.status     = ST_OK;
                    o.out_value  = tab_payload[v][r.slot_id];
                    o.out_rank   = tab_rank[v][r.slot_id];
                    o.slot_valid = 1'b1;
                end
            end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    // Mostly short, now and then long.
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 4);
        else if (r < 95)
            return $urandom_range(5, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] rand_payload();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] rand_slot();
        return 4'($urandom_range(0, 15));
    endfunction

    // Random held slot in the generator's view, or -1 when empty.
    function automatic int pick_held();
        int held [$];
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            if (tab_valid[GEN_VIEW][i])
                held.insert(held.size(), i);
        end
        if (held.size() == 0)
            return -1;
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    function automatic int held_count();
        int i;
        int n;
        n = 0;
        for (i = 0; i < SLOTS; i++)
            n += tab_valid[GEN_VIEW][i];
        return n;
    endfunction

    task automatic push_req(input logic [2:0] kind, input logic [3:0] sid,
                            input logic [31:0] val);
        req_t r;
        r.req_type   = kind;
        r.slot_id    = sid;
        r.item_value = val;
        pending_reqs.insert(pending_reqs.size(), r);
        void'(table_step(GEN_VIEW, r));
        n_gen++;
    endtask

    // Run one slot up past the rank ceiling.
    task automatic saturate_one();
        int s;
        int k;
        s = pick_held();
        if (s < 0)
        begin
            push_req(REQ_ADD, rand_slot(), rand_payload());
            s = pick_held();
        end
        k = RANK_MAX + 3 - int'(tab_rank[GEN_VIEW][s]);
        repeat (k)
            push_req(REQ_PROMOTE, 4'(s), rand_payload());
    endtask

    initial
    begin
        int v;
        int i;
        int n;
        int s;
        int sat_runs;
        int unsigned r;
        for (v = 0; v < 2; v++)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                tab_valid[v][i]   = 1'b0;
                tab_payload[v][i] = '0;
                tab_rank[v][i]    = '0;
                tab_seq[v][i]     = '0;
            end
            tab_next_seq[v] = '0;
        end
        sat_runs = 0;

        // directed: empty table, bad slots, spare codes, ties, full table
        push_req(REQ_PEEK, rand_slot(), rand_payload());
        push_req(REQ_POP, rand_slot(), rand_payload());
        push_req(REQ_PROMOTE, 4'd0, rand_payload());
        push_req(REQ_READ, 4'd15, rand_payload());
        push_req(REQ_ISVALID, 4'd3, rand_payload());
        push_req(REQ_SPARE6, rand_slot(), rand_payload());
        push_req(REQ_SPARE7, rand_slot(), rand_payload());
        push_req(REQ_ADD, rand_slot(), 32'h0000_0000);
        push_req(REQ_ADD, rand_slot(), 32'hFFFF_FFFF);
        push_req(REQ_PEEK, rand_slot(), rand_payload());
        push_req(REQ_PROMOTE, 4'd0, rand_payload());
        push_req(REQ_PEEK, rand_slot(), rand_payload());
        push_req(REQ_ISVALID, 4'd0, rand_payload());
        push_req(REQ_READ, 4'd1, rand_payload());
        repeat (SLOTS - 2)
            push_req(REQ_ADD, rand_slot(), rand_payload());
        push_req(REQ_ADD, rand_slot(), rand_payload());
        push_req(REQ_POP, rand_slot(), rand_payload());

        while (n_gen < N_ITEMS)
        begin
            if ((n_gen > 300 && sat_runs == 0) || (n_gen > 750 && sat_runs == 1))
            begin
                saturate_one();
                sat_runs++;
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 10)
                push_req(3'($urandom_range(0, 7)), rand_slot(), rand_payload());
            else if (r < 35)
            begin
                n = $urandom_range(1, SLOTS + 1 - held_count());
                repeat (n)
                    push_req(REQ_ADD, rand_slot(), rand_payload());
            end
            else if (r < 60)
            begin
                s = pick_held();
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(0, 3) == 0)
                        s = pick_held();
                    push_req(REQ_PROMOTE, s < 0 ? rand_slot() : 4'(s), rand_payload());
                end
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 6))
                    push_req($urandom_range(0, 9) < 7 ? REQ_POP : REQ_PEEK,
                             rand_slot(), rand_payload());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    s = ($urandom_range(0, 3) != 0) ? pick_held() : -1;
                    push_req($urandom_range(0, 1) ? REQ_READ : REQ_ISVALID,
                             s < 0 ? rand_slot() : 4'(s), rand_payload());
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // every generated word must come back checked
        while (n_rsp < n_gen)
            @(posedge clk);
        repeat (SLOTS * 4) @(posedge clk);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Request driver: a word stays put until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                rsp_expected.insert(rsp_expected.size(), table_step(CHK_VIEW, req));
                n_acc++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left != 0)
                begin
                    req_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    // every fourth stretch of 128 words runs back to back
                    if ((n_acc / 128) % 4 == 2 || $urandom_range(0, 1) == 0)
                        gap_left <= 0;
                    else
                        gap_left <= pick_len();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input.
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (cyc_cnt == 3000 || cyc_cnt == 20000)
            hold_left <= 400;
    end

    // Response monitor and stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_rsp++;
                if (rsp_expected.size() == 0)
                begin
                    $error("response word with nothing expected");
                    fail_cnt++;
                end
                else
                begin
                    e = rsp_expected.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                        fail_cnt++;
                    end
                    if (rsp.out_slot !== e.out_slot)
                    begin
                        $error("out_slot: expected %0d, got %0d", e.out_slot, rsp.out_slot);
                        fail_cnt++;
                    end
                    if (rsp.out_value !== e.out_value)
                    begin
                        $error("out_value: expected %h, got %h", e.out_value, rsp.out_value);
                        fail_cnt++;
                    end
                    if (rsp.out_rank !== e.out_rank)
                    begin
                        $error("out_rank: expected %0d, got %0d", e.out_rank, rsp.out_rank);
                        fail_cnt++;
                    end
                    if (rsp.slot_valid !== e.slot_valid)
                    begin
                        $error("slot_valid: expected %0d, got %0d",
                               e.slot_valid, rsp.slot_valid);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left != 0)
                rsp_stall <= 1'b1;
            else if (stall_left != 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if ((n_rsp / 128) % 4 == 3)
                rsp_stall <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= pick_len() - 1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

endmodule

@@ priority_table_increase_key.f @@
hdl/ptik_pkg.sv
hdl/ptik_cell.sv
hdl/priority_table_increase_key.sv
dv/tb.sv
